[src/lrcr_pkg.sv]
package lrcr_pkg;

    // Grid and coordinate sizing.
    localparam int GRID_SIZE = 64;
    localparam int COORD_W   = 6;

    // Signed width of the doubled cross-product error term.
    localparam int DERR_W    = 15;

    // Depth of the command queue between front and back.
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef logic [COORD_W-1:0] t_coord;

    // One classified line command, ordered so that the column rises.
    typedef struct packed {
        t_coord c0;
        t_coord r0;
        t_coord c1;
        t_coord span;
        t_coord rise;
        logic   down;
    } t_cmd;

    // Saturates a coordinate to the last grid position.
    function automatic t_coord clamp_coord(input t_coord v);
        t_coord res;
        res = v;
        if (int'(v) > GRID_SIZE - 1) begin
            res = COORD_W'(GRID_SIZE - 1);
        end
        return res;
    endfunction

endpackage

[src/lrcr_cmd_if.sv]
interface lrcr_cmd_if import lrcr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord start_col;
    t_coord start_row;
    t_coord end_col;
    t_coord end_row;

    modport source (output valid, output start_col, output start_row,
                    output end_col, output end_row, input ready);
    modport sink   (input valid, input start_col, input start_row,
                    input end_col, input end_row, output ready);
endinterface

[src/lrcr_run_if.sv]
interface lrcr_run_if import lrcr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord column;
    t_coord row_first;
    t_coord row_last;
    logic   last;

    modport source (output valid, output column, output row_first,
                    output row_last, output last, input ready);
    modport sink   (input valid, input column, input row_first,
                    input row_last, input last, output ready);
endinterface

[src/lrcr_front.sv]
module lrcr_front import lrcr_pkg::*; (
    lrcr_cmd_if.sink i_cmd,
    output logic     o_valid,
    output t_cmd     o_cmd,
    input  logic     i_ready
);

    t_coord sc;
    t_coord sr;
    t_coord ec;
    t_coord er;
    t_coord c0;
    t_coord r0;
    t_coord c1;
    t_coord r1;

    // Saturate the endpoints and order them so the column rises.
    always_comb begin
        sc = clamp_coord(i_cmd.start_col);
        sr = clamp_coord(i_cmd.start_row);
        ec = clamp_coord(i_cmd.end_col);
        er = clamp_coord(i_cmd.end_row);
        if (sc > ec) begin
            c0 = ec;
            r0 = er;
            c1 = sc;
            r1 = sr;
        end else begin
            c0 = sc;
            r0 = sr;
            c1 = ec;
            r1 = er;
        end
    end

    // Column span, row rise and row direction of the ordered line.
    always_comb begin
        o_cmd.c0   = c0;
        o_cmd.r0   = r0;
        o_cmd.c1   = c1;
        o_cmd.span = c1 - c0;
        o_cmd.down = (r1 < r0);
        o_cmd.rise = (r1 < r0) ? (r0 - r1) : (r1 - r0);
    end

    assign o_valid     = i_cmd.valid;
    assign i_cmd.ready = i_ready;

endmodule

[src/lrcr_queue.sv]
module lrcr_queue import lrcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = o_valid && i_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("command queue overfilled");

endmodule

[src/lrcr_back.sv]
module lrcr_back import lrcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cmd       i_cmd,
    lrcr_run_if.source o_run
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                     r_state;
    logic                     n_state;
    t_cmd                     r_cmd;
    t_cmd                     n_cmd;
    t_coord                   r_col;
    t_coord                   n_col;
    t_coord                   r_cur;
    t_coord                   n_cur;
    t_coord                   r_k;
    t_coord                   n_k;
    t_coord                   r_first;
    t_coord                   n_first;
    logic                     r_stepped;
    logic                     n_stepped;
    logic signed [DERR_W-1:0] r_d;
    logic signed [DERR_W-1:0] n_d;
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_coord                   r_out_col;
    t_coord                   n_out_col;
    t_coord                   r_out_first;
    t_coord                   n_out_first;
    t_coord                   r_out_last_row;
    t_coord                   n_out_last_row;
    logic                     r_out_last;
    logic                     n_out_last;

    logic                     step;
    logic                     can_out;
    logic                     emit;
    t_coord                   cur_next;
    logic        [DERR_W-1:0] two_span;
    logic        [DERR_W-1:0] two_rise;

    // Step while the end row is not reached and the next row is no worse.
    assign step     = (r_k < r_cmd.rise) && !r_d[DERR_W-1];
    assign can_out  = !r_out_valid || o_run.ready;
    assign emit     = (r_state == ST_RUN) && !step && can_out;
    assign cur_next = r_cmd.down ? (r_cur - 1'b1) : (r_cur + 1'b1);
    assign two_span = DERR_W'({r_cmd.span, 1'b0});
    assign two_rise = DERR_W'({r_cmd.rise, 1'b0});
    assign o_ready  = (r_state == ST_IDLE);

    // Sequencer: one row step or one column result per cycle, unless a column result is held by a stalled output.
    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_col          = r_col;
        n_cur          = r_cur;
        n_k            = r_k;
        n_first        = r_first;
        n_stepped      = r_stepped;
        n_d            = r_d;
        n_out_valid    = r_out_valid && !o_run.ready;
        n_out_col      = r_out_col;
        n_out_first    = r_out_first;
        n_out_last_row = r_out_last_row;
        n_out_last     = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state   = ST_RUN;
                    n_cmd     = i_cmd;
                    n_col     = i_cmd.c0;
                    n_cur     = i_cmd.r0;
                    n_first   = i_cmd.r0;
                    n_k       = '0;
                    n_stepped = 1'b0;
                    n_d       = -$signed(DERR_W'({1'b0, i_cmd.span}));
                end
            end
            ST_RUN: begin
                if (step) begin
                    n_cur     = cur_next;
                    n_k       = r_k + 1'b1;
                    n_d       = r_d - $signed(two_span);
                    n_stepped = 1'b1;
                    if (!r_stepped && (r_col != r_cmd.c0)) begin
                        n_first = cur_next;
                    end
                end else if (can_out) begin
                    n_out_valid    = 1'b1;
                    n_out_col      = r_col;
                    n_out_first    = r_first;
                    n_out_last_row = r_cur;
                    n_out_last     = (r_col == r_cmd.c1);
                    if (r_col == r_cmd.c1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_col     = r_col + 1'b1;
                        n_d       = r_d + $signed(two_rise);
                        n_first   = r_cur;
                        n_stepped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_col          <= n_col;
        r_cur          <= n_cur;
        r_k            <= n_k;
        r_first        <= n_first;
        r_stepped      <= n_stepped;
        r_d            <= n_d;
        r_out_col      <= n_out_col;
        r_out_first    <= n_out_first;
        r_out_last_row <= n_out_last_row;
        r_out_last     <= n_out_last;
    end

    assign o_run.valid     = r_out_valid;
    assign o_run.column    = r_out_col;
    assign o_run.row_first = r_out_first;
    assign o_run.row_last  = r_out_last_row;
    assign o_run.last      = r_out_last;

    // The row never travels past the end row.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_k <= r_cmd.rise))
        else $error("row stepped past the end row");

    // A step taken in this column implies the row has moved off the start.
    a_step_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && r_stepped) |-> (r_k != '0))
        else $error("step flag set without a row step");

    // Emitting the final column returns the sequencer to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_col == r_cmd.c1)) |=> (r_state == ST_IDLE) && r_out_last)
        else $error("line did not finish after its final column");

endmodule

[src/line_raster_column_runs_top.sv]
// Flow: an accepted line passes the command queue into the back sequencer, which
// registers each column word at the output after the row steps of that column.
// Throughput: the back sequencer evaluates one row step or column per cycle while
// the output is not stalled, and takes a new line only once the last one is done.
// Reset: synchronous, active low; empties the command queue, idles the sequencer
// and drops any pending output word.
module line_raster_column_runs_top import lrcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrcr_cmd_if.sink   i_cmd,
    lrcr_run_if.source o_run
);

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    // Classify incoming line commands.
    lrcr_front u_front (
        .i_cmd   (i_cmd),
        .o_valid (f_valid),
        .o_cmd   (f_cmd),
        .i_ready (f_ready)
    );

    // Short queue decoupling front and back.
    lrcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    // Walk the columns and emit one run word per column.
    lrcr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cmd   (q_cmd),
        .o_run   (o_run)
    );

endmodule
